// ----- rtl/mad_pkg.sv -----
// mad_pkg: shared constants, widths and the job record for the moving average block.
// Depends on nothing; every other file refers to it by scoped names.
package mad_pkg;

    // Ring store capacity and the widths that follow from it
    localparam int CAPACITY  = 64;
    localparam int PTR_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = SAMPLE_W + $clog2(CAPACITY);
    localparam int AVG_W     = 16;
    localparam int DEV_W     = 17;
    localparam int WLEN_W    = 7;
    localparam int STEP_W    = $clog2(SUM_W + 1);

    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(16);

    // Job queue between front and back
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 2 ** QPTR_W;

    // One classified sample handed from the front to the divider
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SUM_W-1:0]    sum;
        logic [CNT_W-1:0]           divisor;
        logic                       filled;
    } mad_job_t;

endpackage

// ----- rtl/mad_ifs.sv -----
// mad_ifs: valid/ready channel interfaces for samples, results and configuration.
// Depends on mad_pkg for field widths.

interface mad_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mad_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mad_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [mad_pkg::DEV_W-1:0] deviation;
    logic signed [mad_pkg::AVG_W-1:0] average;
    logic                             window_filled;

    modport source (output valid, output deviation, output average,
                    output window_filled, input ready);
    modport sink   (input valid, input deviation, input average,
                    input window_filled, output ready);
endinterface

interface mad_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [mad_pkg::WLEN_W-1:0]  window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

// ----- rtl/mad_front.sv -----
// mad_front: accepts samples, keeps the ring store, running sum and write position,
// and hands one job per sample to the queue. Depends on mad_pkg and mad_ifs.
module mad_front (
    input  logic                  clk,
    input  logic                  rst_n,
    mad_in_if.sink                samples,
    mad_cfg_if.sink               cfg,
    output logic                  push_valid,
    input  logic                  push_ready,
    output mad_pkg::mad_job_t     push_job
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_UPD  = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [mad_pkg::WLEN_W-1:0]          wlen_reg;
    logic signed [mad_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [mad_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [mad_pkg::PTR_W-1:0]           pos_reg, pos_next;
    logic                                filled_reg, filled_next;
    logic [mad_pkg::CAPACITY-1:0]        slot_valid_reg;
    logic                                old_valid_reg;
    logic signed [mad_pkg::SAMPLE_W-1:0] rd_data_reg;

    logic signed [mad_pkg::SAMPLE_W-1:0] ring_mem [mad_pkg::CAPACITY];

    logic                                accept;
    logic [mad_pkg::CNT_W-1:0]           eff_len;
    logic [mad_pkg::CNT_W-1:0]           pos_inc;
    logic                                wrap;
    logic signed [mad_pkg::SAMPLE_W-1:0] old_sample;

    assign samples.ready = (state_reg == F_IDLE) && push_ready;
    assign accept        = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;

    // Clamp the window length to 1..CAPACITY
    always_comb
    begin
        if (wlen_reg == '0)
            eff_len = mad_pkg::CNT_W'(1);
        else if (int'(wlen_reg) > mad_pkg::CAPACITY)
            eff_len = mad_pkg::CNT_W'(mad_pkg::CAPACITY);
        else
            eff_len = mad_pkg::CNT_W'(wlen_reg);
    end

    // Replace the oldest slot and advance the position
    always_comb
    begin
        old_sample  = old_valid_reg ? rd_data_reg : '0;
        sum_next    = sum_reg - mad_pkg::SUM_W'(old_sample) + mad_pkg::SUM_W'(sample_reg);
        pos_inc     = mad_pkg::CNT_W'(pos_reg) + mad_pkg::CNT_W'(1);
        wrap        = (pos_inc >= eff_len);
        filled_next = filled_reg || wrap;
        pos_next    = wrap ? '0 : pos_inc[mad_pkg::PTR_W-1:0];
        state_next  = state_reg;
        case (state_reg)
            F_IDLE:  if (accept) state_next = F_UPD;
            F_UPD:   state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    assign push_valid       = (state_reg == F_UPD);
    assign push_job.sample  = sample_reg;
    assign push_job.sum     = sum_next;
    assign push_job.divisor = filled_reg ? eff_len : pos_inc;
    assign push_job.filled  = filled_next;

    // Ring store: registered read on transfer, write during the update cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= ring_mem[pos_reg];
        if (state_reg == F_UPD)
            ring_mem[pos_reg] <= sample_reg;
    end

    // Hold the sample and the slot valid bit read alongside it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg    <= samples.sample;
            old_valid_reg <= slot_valid_reg[pos_reg];
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            wlen_reg       <= mad_pkg::WLEN_RESET;
            sum_reg        <= '0;
            pos_reg        <= '0;
            filled_reg     <= 1'b0;
            slot_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                wlen_reg <= cfg.window_length;
            if (state_reg == F_UPD)
            begin
                sum_reg                 <= sum_next;
                pos_reg                 <= pos_next;
                filled_reg              <= filled_next;
                slot_valid_reg[pos_reg] <= 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mad_queue.sv -----
// mad_queue: short job queue that decouples the front from the divider.
// Depends on mad_pkg for the job record and depth.
module mad_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  mad_pkg::mad_job_t     push_job,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output mad_pkg::mad_job_t     pop_job
);

    mad_pkg::mad_job_t         job_mem [mad_pkg::QUEUE_DEPTH];
    logic [mad_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mad_pkg::QPTR_W:0]   count_reg;
    logic                       do_push, do_pop;

    assign push_ready = (count_reg != (mad_pkg::QPTR_W+1)'(mad_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = job_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (do_push)
            job_mem[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/mad_back.sv -----
// mad_back: bit-serial divide of the running sum by the sample count, saturation,
// deviation and the output register. Depends on mad_pkg and mad_ifs.
module mad_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  mad_pkg::mad_job_t     pop_job,
    mad_out_if.source             results
);

    localparam int SUM_W = mad_pkg::SUM_W;
    localparam int CNT_W = mad_pkg::CNT_W;
    localparam logic signed [SUM_W:0] AVG_MAX = (SUM_W+1)'(32767);
    localparam logic signed [SUM_W:0] AVG_MIN = -(SUM_W+1)'(32768);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic signed [mad_pkg::SAMPLE_W-1:0] sample_reg;
    logic                                filled_reg;
    logic                                neg_reg;
    logic [CNT_W-1:0]                    div_reg;
    logic [CNT_W-1:0]                    rem_reg;
    logic [SUM_W-1:0]                    quot_reg;
    logic [mad_pkg::STEP_W-1:0]          step_reg;

    logic                                out_valid_reg;
    logic signed [mad_pkg::DEV_W-1:0]    dev_reg;
    logic signed [mad_pkg::AVG_W-1:0]    avg_reg;
    logic                                filled_out_reg;

    logic [CNT_W:0]                      trial;
    logic                                fits;
    logic [CNT_W-1:0]                    rem_next;
    logic [SUM_W-1:0]                    mag;
    logic signed [SUM_W:0]               quot_signed;
    logic signed [mad_pkg::AVG_W-1:0]    avg_sat;
    logic signed [mad_pkg::DEV_W-1:0]    dev_calc;
    logic                                out_free;
    logic                                load_out;

    assign pop_ready = (state_reg == B_IDLE);
    assign out_free  = !out_valid_reg || results.ready;
    assign load_out  = (state_reg == B_DONE) && out_free;

    // Magnitude of the incoming sum
    assign mag = pop_job.sum[SUM_W-1] ? SUM_W'(-pop_job.sum) : SUM_W'(pop_job.sum);

    // One restoring divide step
    always_comb
    begin
        trial    = {rem_reg, quot_reg[SUM_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
    end

    // Restore the sign, saturate, form the deviation
    always_comb
    begin
        quot_signed = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
        if (quot_signed > AVG_MAX)
            avg_sat = mad_pkg::AVG_W'(AVG_MAX);
        else if (quot_signed < AVG_MIN)
            avg_sat = mad_pkg::AVG_W'(AVG_MIN);
        else
            avg_sat = quot_signed[mad_pkg::AVG_W-1:0];
        dev_calc = mad_pkg::DEV_W'(sample_reg) - mad_pkg::DEV_W'(avg_sat);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (pop_valid) state_next = B_DIV;
            B_DIV:   if (step_reg == mad_pkg::STEP_W'(1)) state_next = B_DONE;
            B_DONE:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Divider datapath: load on transfer, then shift one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && pop_valid)
        begin
            sample_reg <= pop_job.sample;
            filled_reg <= pop_job.filled;
            neg_reg    <= pop_job.sum[SUM_W-1];
            div_reg    <= pop_job.divisor;
            rem_reg    <= '0;
            quot_reg   <= mag;
        end
        else if (state_reg == B_DIV)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[SUM_W-2:0], fits};
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            dev_reg        <= dev_calc;
            avg_reg        <= avg_sat;
            filled_out_reg <= filled_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE && pop_valid)
                step_reg <= mad_pkg::STEP_W'(SUM_W);
            else if (state_reg == B_DIV)
                step_reg <= step_reg - 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.deviation     = dev_reg;
    assign results.average       = avg_reg;
    assign results.window_filled = filled_out_reg;

endmodule

// ----- rtl/moving_average_deviation_top.sv -----
// Windowed moving average of signed Q8.8 samples with a deviation output: each
// sample replaces the oldest of 64 ring slots, the running sum is updated and divided
// by the samples seen (until the window first fills) or by the clamped window length,
// truncating toward zero; the average saturates to 16 bits and the deviation is the
// sample minus that average. The front takes a sample and then updates the store
// before it takes another; the result then goes through a one-bit-a-cycle divider of
// 22 steps, which sets the sustained rate. A two-entry job queue lets the front take
// the next sample while a division runs, and the output register holds a finished
// result while the next is computed. Reset empties the ring at once through per-slot
// valid bits; there is no clearing pass. Configuration writes are taken at any time
// (cfg.ready is held high) but belong in idle periods.
// Depends on mad_pkg, mad_ifs, mad_front, mad_queue and mad_back.
module moving_average_deviation_top (
    input  logic       clk,
    input  logic       rst_n,
    mad_in_if.sink     samples,
    mad_cfg_if.sink    cfg,
    mad_out_if.source  results
);

    logic              push_valid, push_ready;
    logic              pop_valid, pop_ready;
    mad_pkg::mad_job_t push_job, pop_job;

    // Classify and update the store
    mad_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Decouple front and divider
    mad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Divide and deliver
    mad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .results   (results)
    );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking testbench for the moving average and deviation block.
// Depends on mad_pkg, the channel interfaces in mad_ifs and moving_average_deviation_top.
module tb;

    typedef struct packed {
        logic signed [mad_pkg::DEV_W-1:0] deviation;
        logic signed [mad_pkg::AVG_W-1:0] average;
        logic                             window_filled;
    } avg_result_t;

    typedef enum logic [1:0] {MIX_FULL, MIX_HIGH, MIX_LOW, MIX_SMALL} sample_mix_t;
    typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    mad_in_if  samples_if ();
    mad_cfg_if cfg_if ();
    mad_out_if results_if ();

    moving_average_deviation_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .cfg     (cfg_if),
        .results (results_if)
    );

    // Samples waiting to be offered, and averages still owed by the block
    logic signed [mad_pkg::SAMPLE_W-1:0] pending_samples [$];
    avg_result_t                         owed_averages [$];
    int                                  errors = 0;
    int                                  results_seen;

    // Own copy of the window state
    logic signed [mad_pkg::SAMPLE_W-1:0] hist_ring [mad_pkg::CAPACITY];
    logic signed [mad_pkg::SUM_W-1:0]    hist_sum;
    int unsigned                         hist_pos;
    logic                                hist_filled;
    logic [mad_pkg::WLEN_W-1:0]          window_reg;

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Take one sample into the window and work out the average it yields
    function automatic avg_result_t next_average(
        input logic signed [mad_pkg::SAMPLE_W-1:0] s);
        int unsigned span;
        int unsigned slot;
        longint      quotient;
        logic        was_filled;
        avg_result_t r;
        span = (window_reg == 0) ? 1 :
               ((window_reg > mad_pkg::CAPACITY) ? mad_pkg::CAPACITY : window_reg);
        slot = hist_pos;
        was_filled = hist_filled;
        hist_sum = hist_sum - hist_ring[slot] + s;
        hist_ring[slot] = s;
        slot++;
        if (was_filled)
            quotient = longint'(hist_sum) / longint'(span);
        else
            quotient = longint'(hist_sum) / longint'(slot);
        // Wrap once the write position reaches the window
        if (slot >= span)
        begin
            slot = 0;
            hist_filled = 1'b1;
        end
        hist_pos = slot;
        // Saturate the average when stale entries push it out of range
        if (quotient > 32767)
            quotient = 32767;
        if (quotient < -32768)
            quotient = -32768;
        r.average = mad_pkg::AVG_W'(quotient);
        r.deviation = mad_pkg::DEV_W'(longint'(s) - quotient);
        r.window_filled = hist_filled;
        return r;
    endfunction

    function automatic logic signed [mad_pkg::SAMPLE_W-1:0] draw_sample(
        input sample_mix_t mix);
        logic signed [mad_pkg::SAMPLE_W-1:0] v;
        int                                  t;
        v = mad_pkg::SAMPLE_W'($urandom);
        if ($urandom_range(0, 9) < 7)
        begin
            case (mix)
                MIX_HIGH:
                    v = mad_pkg::SAMPLE_W'($urandom_range(32000, 32767));
                MIX_LOW:
                begin
                    t = $urandom_range(32000, 32768);
                    v = mad_pkg::SAMPLE_W'(-t);
                end
                MIX_SMALL:
                begin
                    t = $urandom_range(0, 600);
                    v = mad_pkg::SAMPLE_W'(t - 300);
                end
                default:
                    v = mad_pkg::SAMPLE_W'($urandom);
            endcase
        end
        else if ($urandom_range(0, 9) == 0)
            v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        return v;
    endfunction

    // Sample driver: bursts of random length separated by random gaps
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_if.valid <= 1'b0;
            samples_if.sample <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!samples_if.valid || samples_if.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                samples_if.valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                samples_if.valid <= 1'b1;
                samples_if.sample <= pending_samples.pop_front();
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else
                samples_if.valid <= 1'b0;
        end
    end

    // Result receiver: changing stall modes, plus one long hold-off while input is queued
    rx_mode_t    rx_mode;
    int unsigned mode_left;
    int unsigned hold_left;
    logic        long_hold_done;
    logic [31:0] stall_bits;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            rx_mode = RX_ALWAYS;
            mode_left = 0;
            hold_left = 0;
            long_hold_done = 1'b0;
            stall_bits = '0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            results_if.ready <= 1'b0;
        end
        else if (!long_hold_done && pending_samples.size() > 40)
        begin
            long_hold_done = 1'b1;
            hold_left = 400;
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 300);
                stall_bits = $urandom;
            end
            else
                mode_left--;
            case (rx_mode)
                RX_ALWAYS:
                    results_if.ready <= 1'b1;
                RX_PATTERN:
                begin
                    results_if.ready <= stall_bits[0];
                    stall_bits = {stall_bits[0], stall_bits[31:1]};
                end
                default:
                    results_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Monitor: check each result transfer, track configuration, predict each sample transfer
    always @(posedge clk or negedge rst_n)
    begin
        avg_result_t want;
        if (!rst_n)
        begin
            foreach (hist_ring[i])
                hist_ring[i] = '0;
            hist_sum = '0;
            hist_pos = 0;
            hist_filled = 1'b0;
            window_reg = mad_pkg::WLEN_RESET;
            owed_averages.delete();
            results_seen <= 0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                results_seen <= results_seen + 1;
                if (owed_averages.size() == 0)
                begin
                    $error("result transfer with no sample outstanding");
                    errors++;
                end
                else
                begin
                    want = owed_averages.pop_front();
                    if (results_if.deviation !== want.deviation)
                    begin
                        $error("deviation: expected %0d, got %0d", want.deviation,
                               results_if.deviation);
                        errors++;
                    end
                    if (results_if.average !== want.average)
                    begin
                        $error("average: expected %0d, got %0d", want.average,
                               results_if.average);
                        errors++;
                    end
                    if (results_if.window_filled !== want.window_filled)
                    begin
                        $error("window_filled: expected %0d, got %0d", want.window_filled,
                               results_if.window_filled);
                        errors++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                window_reg = cfg_if.window_length;
            if (samples_if.valid && samples_if.ready)
                owed_averages.push_back(next_average(samples_if.sample));
        end
    end

    task automatic write_window(input logic [mad_pkg::WLEN_W-1:0] len);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.window_length <= len;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Block the caller until every sample is through, then let the pipeline settle
    task automatic wait_drained(input int unsigned settle);
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || samples_if.valid || owed_averages.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int unsigned issued;
        int unsigned phase;
        int unsigned phase_len;
        sample_mix_t mix;
        logic [mad_pkg::WLEN_W-1:0] span;

        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.window_length = mad_pkg::WLEN_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset window of 16: field extremes, then fill with full scale so the window wraps
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h0000);
        pending_samples.push_back(16'hFFFF);
        pending_samples.push_back(16'h0001);
        repeat (11) pending_samples.push_back(16'h7FFF);
        wait_drained(30);

        // Shorten to one: stale entries stay in the sum and the average saturates
        write_window(1);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h0000);
        wait_drained(30);

        // Window length zero behaves as one
        write_window(0);
        pending_samples.push_back(16'h0001);
        pending_samples.push_back(16'h8000);
        wait_drained(30);

        // Length above capacity clamps to the full store
        write_window(127);
        pending_samples.push_back(16'h7FFF);
        pending_samples.push_back(16'h8000);
        pending_samples.push_back(16'h5555);
        pending_samples.push_back(16'hAAAA);
        wait_drained(30);

        // Random phases, each with its own window length and sample mix
        issued = 0;
        phase = 0;
        while (issued < 1300)
        begin
            case ($urandom_range(0, 9))
                0:       span = 0;
                1:       span = 1;
                2:       span = 2;
                3:       span = 64;
                4:       span = mad_pkg::WLEN_W'($urandom_range(65, 127));
                default: span = mad_pkg::WLEN_W'($urandom_range(1, 64));
            endcase
            write_window(span);
            mix = sample_mix_t'($urandom_range(0, 3));
            phase_len = (phase == 3) ? 100 : $urandom_range(10, 120);
            repeat (phase_len) pending_samples.push_back(draw_sample(mix));
            issued += phase_len;
            phase++;
            wait_drained(30);
        end

        wait_drained(60);
        if (owed_averages.size() != 0)
            $error("%0d results never arrived", owed_averages.size());
        if (errors == 0 && owed_averages.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $error("run timed out");
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mad_pkg.sv
rtl/mad_ifs.sv
rtl/mad_front.sv
rtl/mad_queue.sv
rtl/mad_back.sv
rtl/moving_average_deviation_top.sv
verif/tb.sv
